// File: rtl/quadrature_decoder_counter_macros.svh
// Assertion helpers for the quadrature decoder counter.
`ifndef QUADRATURE_DECODER_COUNTER_MACROS_SVH
`define QUADRATURE_DECODER_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define QDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qdc assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define QDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qdc assertion failed");

`else

`define QDC_ASSERT_NOW(lbl, ante, cons)
`define QDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/qdc_pkg.sv
package qdc_pkg;

	typedef enum logic [1:0] {
		OP_EDGE  = 2'd0,
		OP_POLL  = 2'd1,
		OP_DELTA = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	localparam logic [1:0] AB_MASK = 2'h3;

	// 4x decode: index {previous AB, current AB}; 1 = +1, -1 = -1, 0 = none/invalid
	localparam logic signed [1:0] STEP_LUT [16] = '{
		 2'sd0,  2'sd1, -2'sd1,  2'sd0,
		-2'sd1,  2'sd0,  2'sd0,  2'sd1,
		 2'sd1,  2'sd0,  2'sd0, -2'sd1,
		 2'sd0, -2'sd1,  2'sd1,  2'sd0
	};

	// One channel's stored record
	typedef struct packed {
		logic [1:0]  decode_state;
		logic [1:0]  polled_state;
		logic [3:0]  observed_states;
		logic [31:0] poll_changes;
		logic [63:0] position_total;
		logic [63:0] reported_total;
	} chan_rec_t;

endpackage

// File: rtl/qdc_chan_update.sv
module qdc_chan_update import qdc_pkg::*; (
	input  op_t                op,
	input  logic [1:0]         ab,
	input  chan_rec_t          cur,
	output chan_rec_t          nxt,
	output logic signed [31:0] delta
);

	logic signed [1:0] step;
	logic [31:0]       diff_lo;

	assign step    = STEP_LUT[{cur.decode_state, ab}];
	// only the low word of total - reported is reported
	assign diff_lo = cur.position_total[31:0] - cur.reported_total[31:0];

	always_comb begin
		nxt   = cur;
		delta = '0;
		unique case (op)
			OP_EDGE: begin
				nxt.position_total = cur.position_total + {{62{step[1]}}, step};
				nxt.decode_state   = ab;
			end
			OP_POLL: begin
				nxt.observed_states = cur.observed_states | (4'b0001 << ab);
				if (ab != cur.polled_state) begin
					nxt.poll_changes = cur.poll_changes + 32'd1;
					nxt.polled_state = ab;
				end
			end
			OP_DELTA: begin
				delta              = signed'(diff_lo);
				nxt.reported_total = cur.position_total;
			end
			OP_RESET: begin
				nxt.decode_state    = ab;
				nxt.polled_state    = ab;
				nxt.observed_states = 4'b0001 << ab;
				nxt.poll_changes    = '0;
				nxt.position_total  = '0;
				nxt.reported_total  = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: rtl/quadrature_decoder_counter.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// input     | in        | in_valid / in_ready  | op, channel, pin_a, pin_b
// result    | out       | out_valid / out_ready| delta, total, raw_state, seen_mask,
//           |           |                      | change_count
//
// One item per clock sustained while the result is not stalled; an accepted item
// moves through stage 1 into the result register. The per-channel record memory has a
// synchronous read, so stage 1 holds the read data; a record written back by the item
// ahead is forwarded to the one behind. Reset clears the per-entry valid bits, not the
// memory contents; an unwritten entry reads as zero. A stalled result holds stage 1,
// and the input is taken again once the result register frees up (same cycle as out_ready).
`include "quadrature_decoder_counter_macros.svh"

module quadrature_decoder_counter import qdc_pkg::*; #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic               channel,
	input  logic               pin_a,
	input  logic               pin_b,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] delta,
	output logic signed [63:0] total,
	output logic [1:0]         raw_state,
	output logic [3:0]         seen_mask,
	output logic [31:0]        change_count
);

	localparam int              CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	// channel record memory, one entry per channel
	chan_rec_t mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;

	// input side
	logic            in_fire;
	logic [CH_W-1:0] ch_idx;

	// stage 1: memory read data plus the item's controls
	logic            s1_valid_s1;
	op_t             op_s1;
	logic [CH_W-1:0] ch_s1;
	logic [1:0]      ab_s1;
	chan_rec_t       rd_mem_s1;
	logic            rd_vld_s1;
	logic            fwd_s1;
	chan_rec_t       fwd_rec_s1;
	logic            s1_adv;

	chan_rec_t          cur_rec;
	chan_rec_t          upd_rec;
	logic signed [31:0] upd_delta;

	// result register
	logic out_valid_q;

	// channel reset op leaving stage 1
	logic reset_retire;

	// channel number beyond the last saturates
	assign ch_idx = ({31'd0, channel} >= 32'(NUM_CHANNELS)) ? CH_LAST : CH_W'(channel);

	assign s1_adv   = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// write-back in flight to the same channel wins over the stale memory word
	always_comb begin
		if (fwd_s1) begin
			cur_rec = fwd_rec_s1;
		end else if (rd_vld_s1) begin
			cur_rec = rd_mem_s1;
		end else begin
			cur_rec = '0;
		end
	end

	qdc_chan_update u_update (
		.op    (op_s1),
		.ab    (ab_s1),
		.cur   (cur_rec),
		.nxt   (upd_rec),
		.delta (upd_delta)
	);

	// memory: synchronous read at accept, write-back when stage 1 retires
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mem[ch_s1] <= upd_rec;
		end
		if (in_fire) begin
			rd_mem_s1 <= mem[ch_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (s1_adv) begin
			vld_q[ch_s1] <= 1'b1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1      <= op_t'(op);
			ch_s1      <= ch_idx;
			ab_s1      <= {pin_a, pin_b} & AB_MASK;
			rd_vld_s1  <= vld_q[ch_idx];
			fwd_s1     <= s1_adv && (ch_s1 == ch_idx);
			fwd_rec_s1 <= upd_rec;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			delta        <= upd_delta;
			total        <= signed'(upd_rec.position_total);
			raw_state    <= upd_rec.polled_state;
			seen_mask    <= upd_rec.observed_states;
			change_count <= upd_rec.poll_changes;
		end
	end

	assign out_valid = out_valid_q;

	assign reset_retire = s1_adv && (op_s1 == OP_RESET);

	// a free result register always lets an item in
	`QDC_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready)
	// a retired item marks its channel entry as written
	`QDC_ASSERT_NEXT(a_entry_marked, s1_adv, vld_q[$past(ch_s1)])
	// a channel reset shows a single seen state and cleared counters
	`QDC_ASSERT_NEXT(a_reset_result, reset_retire, $onehot(seen_mask) && (change_count == 32'd0))
	`QDC_ASSERT_NEXT(a_reset_total, reset_retire, total == 64'sd0)

endmodule
